// ===== rtl/rmq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants for the matrix-to-quaternion block
// Holds the default format constants and the largest-component index type.
// ----------------------------------------------------------------------------
package rmq_pkg;
    localparam int CompWidth = 16;
    localparam int FracBits  = 14;

    typedef enum logic [1:0] {
        IDX_W = 2'd0,
        IDX_X = 2'd1,
        IDX_Y = 2'd2,
        IDX_Z = 2'd3
    } t_idx;
endpackage
`default_nettype wire

// ===== rtl/rmq_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_front: candidate classification
// Forms the four diagonal candidates, picks the largest, and builds the
// radicand and the three signed off-diagonal terms for the back end.
// ----------------------------------------------------------------------------
module rmq_front #(
    parameter int W = 16,
    parameter int F = 14
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic signed [W-1:0] i_m00, i_m01, i_m02,
    input  wire logic signed [W-1:0] i_m10, i_m11, i_m12,
    input  wire logic signed [W-1:0] i_m20, i_m21, i_m22,
    output logic                     o_valid,
    output rmq_pkg::t_idx            o_idx,
    output logic        [W+2:0]      o_rad,
    output logic signed [W:0]        o_d0, o_d1, o_d2
);
    import rmq_pkg::*;

    logic signed [W+1:0] c0, c1, c2, c3, best;
    t_idx                idx;
    logic signed [W:0]   a0, a1, a2, s0, s1, s2, t0, t1, t2;
    logic signed [W:0]   n_d0, n_d1, n_d2;

    always_comb begin
        c0 = (W+2)'(i_m00) + (W+2)'(i_m11) + (W+2)'(i_m22);
        c1 = (W+2)'(i_m00) - (W+2)'(i_m11) - (W+2)'(i_m22);
        c2 = (W+2)'(i_m11) - (W+2)'(i_m00) - (W+2)'(i_m22);
        c3 = (W+2)'(i_m22) - (W+2)'(i_m00) - (W+2)'(i_m11);
        best = c0;
        idx  = IDX_W;
        if (c1 > best) begin best = c1; idx = IDX_X; end
        if (c2 > best) begin best = c2; idx = IDX_Y; end
        if (c3 > best) begin best = c3; idx = IDX_Z; end
        a0 = (W+1)'(i_m12) - (W+1)'(i_m21);
        a1 = (W+1)'(i_m20) - (W+1)'(i_m02);
        a2 = (W+1)'(i_m01) - (W+1)'(i_m10);
        s0 = (W+1)'(i_m01) + (W+1)'(i_m10);
        s1 = (W+1)'(i_m20) + (W+1)'(i_m02);
        s2 = (W+1)'(i_m12) + (W+1)'(i_m21);
        t0 = a0; t1 = a1; t2 = a2;
        case (idx)
            IDX_W: begin t0 = a0; t1 = a1; t2 = a2; end
            IDX_X: begin t0 = s0; t1 = s1; t2 = a0; end
            IDX_Y: begin t0 = s0; t1 = s2; t2 = a1; end
            default: begin t0 = s1; t1 = s2; t2 = a2; end
        endcase
        n_d0 = t0; n_d1 = t1; n_d2 = t2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= i_valid;
        o_idx <= idx;
        o_rad <= (W+3)'(unsigned'(best + (W+2)'(1 << F)));
        o_d0  <= n_d0;
        o_d1  <= n_d1;
        o_d2  <= n_d2;
    end
endmodule
`default_nettype wire

// ===== rtl/rmq_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_back: root and scaling pipeline
// Pipelined restoring square root, then one pipelined divider per term,
// rounding half away from zero, saturation and final placement.
// ----------------------------------------------------------------------------
module rmq_back #(
    parameter int W = 16,
    parameter int F = 14
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  rmq_pkg::t_idx            i_idx,
    input  wire logic        [W+2:0] i_rad,
    input  wire logic signed [W:0]   i_d0, i_d1, i_d2,
    output logic                     o_valid,
    output logic signed [W-1:0]      o_x, o_y, o_z, o_w,
    output rmq_pkg::t_idx            o_idx
);
    import rmq_pkg::*;

    // radicand S*2^(F-2), padded to an even width so bit pairs line up
    localparam int NB = W + 3 + F - 2;
    localparam int RS = (NB + 1) / 2;
    localparam int NW = 2 * RS;
    localparam int RW = RS;
    localparam int NUMW = W + F + 1;   // width of |d|<<F; the numerator adds one bit for 2c
    localparam int QS = NUMW;           // quotient bit steps
    localparam int DW = RW + 2;         // 4c width

    typedef struct packed {
        logic               v;
        t_idx               idx;
        logic [2:0]         neg;
        logic [NUMW-1:0]    n0, n1, n2;
    } t_meta;

    // square root stages
    logic [NW-1:0]   r_sn [RS+1];
    logic [RW-1:0]   r_sr [RS+1];
    logic [NW+1:0]   r_srem [RS+1];
    t_meta           r_sm [RS+1];
    logic [W:0]      mag0, mag1, mag2;

    always_comb begin
        mag0 = i_d0[W] ? (W+1)'(-i_d0) : i_d0;
        mag1 = i_d1[W] ? (W+1)'(-i_d1) : i_d1;
        mag2 = i_d2[W] ? (W+1)'(-i_d2) : i_d2;
    end

    always_ff @(posedge i_clk) begin
        r_sn[0]   <= NW'(i_rad) << (F - 2);
        r_sr[0]   <= '0;
        r_srem[0] <= '0;
        r_sm[0].idx <= i_idx;
        r_sm[0].neg <= {i_d2[W], i_d1[W], i_d0[W]};
        r_sm[0].n0  <= NUMW'(mag0) << F;
        r_sm[0].n1  <= NUMW'(mag1) << F;
        r_sm[0].n2  <= NUMW'(mag2) << F;
        if (!i_rst_n) r_sm[0].v <= 1'b0;
        else          r_sm[0].v <= i_valid;
    end

    for (genvar k = 0; k < RS; k++) begin : g_sq
        logic [NW+1:0] rem, trial;
        always_comb begin
            rem   = {r_srem[k][NW-1:0], r_sn[k][NW-1 -: 2]};
            trial = (NW+2)'({r_sr[k], 2'b01});
        end
        always_ff @(posedge i_clk) begin
            r_sn[k+1] <= r_sn[k] << 2;
            if (!i_rst_n) r_sm[k+1] <= '0;
            else          r_sm[k+1] <= r_sm[k];
            if (rem >= trial) begin
                r_srem[k+1] <= rem - trial;
                r_sr[k+1]   <= {r_sr[k][RW-2:0], 1'b1};
            end else begin
                r_srem[k+1] <= rem;
                r_sr[k+1]   <= {r_sr[k][RW-2:0], 1'b0};
            end
        end
    end

    // division stages: q = (n + 2c) / 4c, three lanes, one quotient bit a stage
    logic [NUMW:0]   r_num [3][QS+1];
    logic [NUMW:0]   r_rem [3][QS+1];
    logic [NUMW:0]   r_quo [3][QS+1];
    logic [DW-1:0]   r_den [QS+1];
    logic [RW-1:0]   r_c [QS+1];
    t_meta           r_dm [QS+1];

    always_ff @(posedge i_clk) begin
        r_den[0] <= {r_sr[RS], 2'b00};
        r_c[0]   <= r_sr[RS];
        if (!i_rst_n) r_dm[0] <= '0;
        else          r_dm[0] <= r_sm[RS];
        r_num[0][0] <= (NUMW+1)'(r_sm[RS].n0) + (NUMW+1)'({r_sr[RS], 1'b0});
        r_num[1][0] <= (NUMW+1)'(r_sm[RS].n1) + (NUMW+1)'({r_sr[RS], 1'b0});
        r_num[2][0] <= (NUMW+1)'(r_sm[RS].n2) + (NUMW+1)'({r_sr[RS], 1'b0});
        for (int l = 0; l < 3; l++) begin
            r_rem[l][0] <= '0;
            r_quo[l][0] <= '0;
        end
    end

    for (genvar k = 0; k < QS; k++) begin : g_dv
        for (genvar l = 0; l < 3; l++) begin : g_ln
            logic [NUMW+1:0] rem;
            always_comb rem = {r_rem[l][k], r_num[l][k][NUMW]};
            always_ff @(posedge i_clk) begin
                r_num[l][k+1] <= r_num[l][k] << 1;
                if (rem >= (NUMW+2)'(r_den[k])) begin
                    r_rem[l][k+1] <= (NUMW+1)'(rem - (NUMW+2)'(r_den[k]));
                    r_quo[l][k+1] <= {r_quo[l][k][NUMW-1:0], 1'b1};
                end else begin
                    r_rem[l][k+1] <= (NUMW+1)'(rem);
                    r_quo[l][k+1] <= {r_quo[l][k][NUMW-1:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            r_den[k+1] <= r_den[k];
            r_c[k+1]   <= r_c[k];
            if (!i_rst_n) r_dm[k+1] <= '0;
            else          r_dm[k+1] <= r_dm[k];
        end
    end

    // last quotient bit comes from the top numerator bit: one more step
    logic [NUMW+1:0] fin_rem [3];
    logic [NUMW+1:0] q_full [3];
    logic signed [NUMW+2:0] sq [3];
    logic signed [W-1:0] sat [3];
    logic signed [W-1:0] cval;
    localparam logic signed [W-1:0] MaxV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MinV = {1'b1, {(W-1){1'b0}}};

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            fin_rem[l] = {r_rem[l][QS], r_num[l][QS][NUMW]};
            q_full[l]  = {r_quo[l][QS],
                          fin_rem[l] >= (NUMW+2)'(r_den[QS])};
            sq[l] = r_dm[QS].neg[l] ? -$signed({1'b0, q_full[l]})
                                    :  $signed({1'b0, q_full[l]});
            if (sq[l] > (NUMW+3)'(MaxV))      sat[l] = MaxV;
            else if (sq[l] < (NUMW+3)'(MinV)) sat[l] = MinV;
            else                              sat[l] = W'(sq[l]);
        end
        cval = (r_c[QS] > (RW)'(MaxV)) ? MaxV : W'(r_c[QS]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r_dm[QS].v;
        o_idx <= r_dm[QS].idx;
        case (r_dm[QS].idx)
            IDX_W: begin o_x <= sat[0]; o_y <= sat[1]; o_z <= sat[2]; o_w <= cval; end
            IDX_X: begin o_x <= cval; o_y <= sat[0]; o_z <= sat[1]; o_w <= sat[2]; end
            IDX_Y: begin o_x <= sat[0]; o_y <= cval; o_z <= sat[1]; o_w <= sat[2]; end
            default: begin o_x <= sat[0]; o_y <= sat[1]; o_z <= cval; o_w <= sat[2]; end
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sm[RS].v |-> r_sr[RS] >= RW'(1 << (F - 1)))
        else $error("root below half scale");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dm[QS].v |-> r_den[QS] != '0)
        else $error("zero divisor");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sm[0].v |=> ##RS r_dm[0].v)
        else $error("transaction lost between root and divider");
endmodule
`default_nettype wire

// ===== rtl/rotation_matrix_to_quaternion.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: Shepperd conversion, fixed point
// Channel   | Ports                               | Handshake
// command   | i_elem_r*_c*                        | start, busy (never high)
// result    | o_quat_x/y/z/w, o_largest_index     | o_done strobe, one cycle
// One transaction per cycle; o_done follows the accepting edge through the front
// register, the root input register and root stages, the divider input register
// and divider stages, and the output register.
// Synchronous active-low reset empties the pipeline; results cannot stall.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
    parameter int COMPONENT_WIDTH = rmq_pkg::CompWidth,
    parameter int FRACTION_BITS   = rmq_pkg::FracBits
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_elem_r0_c0, i_elem_r0_c1, i_elem_r0_c2,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_elem_r1_c0, i_elem_r1_c1, i_elem_r1_c2,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_elem_r2_c0, i_elem_r2_c1, i_elem_r2_c2,
    output logic                                   o_done,
    output logic signed [COMPONENT_WIDTH-1:0]      o_quat_x, o_quat_y, o_quat_z, o_quat_w,
    output logic [1:0]                             o_largest_index
);
    import rmq_pkg::*;
    localparam int W = COMPONENT_WIDTH;

    logic              f_v;
    t_idx              f_idx, b_idx;
    logic [W+2:0]      f_rad;
    logic signed [W:0] f_d0, f_d1, f_d2;

    assign busy = 1'b0;

    rmq_front #(.W(W), .F(FRACTION_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid(start),
        .i_m00(i_elem_r0_c0), .i_m01(i_elem_r0_c1), .i_m02(i_elem_r0_c2),
        .i_m10(i_elem_r1_c0), .i_m11(i_elem_r1_c1), .i_m12(i_elem_r1_c2),
        .i_m20(i_elem_r2_c0), .i_m21(i_elem_r2_c1), .i_m22(i_elem_r2_c2),
        .o_valid(f_v), .o_idx(f_idx), .o_rad(f_rad),
        .o_d0(f_d0), .o_d1(f_d1), .o_d2(f_d2)
    );

    rmq_back #(.W(W), .F(FRACTION_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(f_v), .i_idx(f_idx), .i_rad(f_rad),
        .i_d0(f_d0), .i_d1(f_d1), .i_d2(f_d2),
        .o_valid(o_done), .o_x(o_quat_x), .o_y(o_quat_y), .o_z(o_quat_z),
        .o_w(o_quat_w), .o_idx(b_idx)
    );

    assign o_largest_index = b_idx;
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for rotation_matrix_to_quaternion
// Drives matrices through the start/busy command port, predicts each
// quaternion in fixed point and compares every done strobe in order.
// ----------------------------------------------------------------------------
module testbench;
    import rmq_pkg::*;

    localparam int W = CompWidth;
    localparam int F = FracBits;
    localparam int N_RANDOM = 1950;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic signed [W-1:0] qx;
        logic signed [W-1:0] qy;
        logic signed [W-1:0] qz;
        logic signed [W-1:0] qw;
        t_idx                idx;
    } t_quat;

    typedef logic signed [W-1:0] t_mat [9];

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic signed [W-1:0] elem [9];
    logic o_done;
    logic signed [W-1:0] o_quat_x, o_quat_y, o_quat_z, o_quat_w;
    logic [1:0] o_largest_index;

    t_quat quat_expected [$];
    int    n_errors;
    int    n_checked;
    int    n_sent;
    int    idx_seen [4];

    rotation_matrix_to_quaternion u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_elem_r0_c0(elem[0]), .i_elem_r0_c1(elem[1]), .i_elem_r0_c2(elem[2]),
        .i_elem_r1_c0(elem[3]), .i_elem_r1_c1(elem[4]), .i_elem_r1_c2(elem[5]),
        .i_elem_r2_c0(elem[6]), .i_elem_r2_c1(elem[7]), .i_elem_r2_c2(elem[8]),
        .o_done(o_done), .o_quat_x(o_quat_x), .o_quat_y(o_quat_y),
        .o_quat_z(o_quat_z), .o_quat_w(o_quat_w), .o_largest_index(o_largest_index)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("rotation_matrix_to_quaternion regression: fail");
        $finish;
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [W-1:0] clamp(longint v);
        longint hi;
        hi = (longint'(1) << (W - 1)) - 1;
        if (v > hi) v = hi;
        if (v < -hi - 1) v = -hi - 1;
        return v[W-1:0];
    endfunction

    // d * 2^F / (4c), nearest, halves away from zero
    function automatic longint off_diag(longint d, longint unsigned c);
        longint unsigned mag;
        longint unsigned q;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        q = ((mag << F) + c * 2) / (c * 4);
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_quat predict_quat(t_mat m);
        longint a [9];
        longint cand [4];
        longint best;
        longint qx, qy, qz, qw;
        longint unsigned c;
        int k;
        t_quat r;
        for (k = 0; k < 9; k++) a[k] = m[k];
        cand[0] = a[0] + a[4] + a[8];
        cand[1] = a[0] - a[4] - a[8];
        cand[2] = a[4] - a[0] - a[8];
        cand[3] = a[8] - a[0] - a[4];
        best = cand[0];
        r.idx = IDX_W;
        for (k = 1; k < 4; k++) begin
            if (cand[k] > best) begin
                best = cand[k];
                r.idx = t_idx'(k);
            end
        end
        c = int_sqrt(longint'(best + (longint'(1) << F)) << (F - 2));
        case (r.idx)
            IDX_W: begin
                qx = off_diag(a[5] - a[7], c); qy = off_diag(a[6] - a[2], c);
                qz = off_diag(a[1] - a[3], c); qw = c;
            end
            IDX_X: begin
                qx = c; qy = off_diag(a[1] + a[3], c);
                qz = off_diag(a[6] + a[2], c); qw = off_diag(a[5] - a[7], c);
            end
            IDX_Y: begin
                qx = off_diag(a[1] + a[3], c); qy = c;
                qz = off_diag(a[5] + a[7], c); qw = off_diag(a[6] - a[2], c);
            end
            default: begin
                qx = off_diag(a[6] + a[2], c); qy = off_diag(a[5] + a[7], c);
                qz = c; qw = off_diag(a[1] - a[3], c);
            end
        endcase
        r.qx = clamp(qx); r.qy = clamp(qy); r.qz = clamp(qz); r.qw = clamp(qw);
        return r;
    endfunction

    // result side: compare each strobe with the oldest prediction
    always @(posedge i_clk) begin
        t_quat exp_q;
        if (i_rst_n && o_done) begin
            if (quat_expected.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d z=%0d w=%0d idx=%0d", $time,
                         o_quat_x, o_quat_y, o_quat_z, o_quat_w, o_largest_index);
                n_errors++;
            end else begin
                exp_q = quat_expected.pop_front();
                n_checked++;
                idx_seen[o_largest_index]++;
                if (o_quat_x !== exp_q.qx || o_quat_y !== exp_q.qy ||
                    o_quat_z !== exp_q.qz || o_quat_w !== exp_q.qw ||
                    o_largest_index !== exp_q.idx) begin
                    $display("%0t: mismatch expected x=%0d y=%0d z=%0d w=%0d idx=%0d",
                             $time, exp_q.qx, exp_q.qy, exp_q.qz, exp_q.qw, exp_q.idx);
                    $display("%0t:          actual   x=%0d y=%0d z=%0d w=%0d idx=%0d",
                             $time, o_quat_x, o_quat_y, o_quat_z, o_quat_w,
                             o_largest_index);
                    n_errors++;
                end
            end
        end
    end

    // one transaction: hold start until accepted, optionally with a typed result
    task automatic send_matrix(t_mat m, bit has_typed, t_quat typed);
        t_quat p;
        int k;
        p = predict_quat(m);
        if (has_typed && p !== typed) begin
            $display("%0t: directed row mismatch expected idx=%0d w=%0d actual predicted w=%0d",
                     $time, typed.idx, typed.qw, p.qw);
            n_errors++;
        end
        for (k = 0; k < 9; k++) elem[k] <= m[k];
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        quat_expected.push_back(has_typed ? typed : p);
        n_sent++;
    endtask

    task automatic idle_gap();
        int n;
        if ($urandom_range(0, 99) < 60) return;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 4);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic logic signed [W-1:0] rand_elem(int mode);
        case (mode)
            0: return W'($urandom);
            1: return W'($signed($urandom_range(0, 2 ** (F + 1))) - 2 ** F);
            default: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    localparam logic signed [W-1:0] ONE = 16'sd16384;
    localparam logic signed [W-1:0] MAXV = 16'sh7fff;
    localparam logic signed [W-1:0] MINV = 16'sh8000;

    initial begin
        t_mat dir_tab [$];
        t_quat dir_typed [$];
        bit dir_has [$];
        t_mat m;
        t_quat t;
        int i, k, mode, wait_cnt;

        start = 1'b0;
        for (k = 0; k < 9; k++) elem[k] = '0;
        n_errors = 0; n_checked = 0; n_sent = 0;
        for (k = 0; k < 4; k++) idx_seen[k] = 0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity: S = 2^16, c = sqrt(2^28) = 2^14, so w is exactly one
        m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
        t = '{qx: 0, qy: 0, qz: 0, qw: 16'sd16384, idx: IDX_W};
        dir_tab.push_back(m); dir_typed.push_back(t); dir_has.push_back(1);
        // all zero: w candidate 0 wins the tie, c = 2^13
        m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        t = '{qx: 0, qy: 0, qz: 0, qw: 16'sd8192, idx: IDX_W};
        dir_tab.push_back(m); dir_typed.push_back(t); dir_has.push_back(1);
        // 180-degree rotations about x, y, z
        dir_tab.push_back('{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE});
        dir_typed.push_back(t); dir_has.push_back(0);
        dir_tab.push_back('{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE});
        dir_typed.push_back(t); dir_has.push_back(0);
        dir_tab.push_back('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE});
        dir_typed.push_back(t); dir_has.push_back(0);
        // ties between candidates
        dir_tab.push_back('{0, 0, 0, 0, 0, 0, 0, 0, -ONE});
        dir_typed.push_back(t); dir_has.push_back(0);
        dir_tab.push_back('{ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE});
        dir_typed.push_back(t); dir_has.push_back(0);
        // extremes and saturation of off-diagonal terms
        dir_tab.push_back('{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV});
        dir_typed.push_back(t); dir_has.push_back(0);
        dir_tab.push_back('{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV});
        dir_typed.push_back(t); dir_has.push_back(0);
        dir_tab.push_back('{0, MAXV, MINV, MINV, 0, MAXV, MAXV, MINV, 0});
        dir_typed.push_back(t); dir_has.push_back(0);
        dir_tab.push_back('{MINV, MAXV, MAXV, MAXV, MINV, MAXV, MAXV, MAXV, MAXV});
        dir_typed.push_back(t); dir_has.push_back(0);
        dir_tab.push_back('{MAXV, MINV, MAXV, MINV, MINV, MINV, MAXV, MINV, MINV});
        dir_typed.push_back(t); dir_has.push_back(0);
        dir_tab.push_back('{MINV, MINV, MAXV, MAXV, MAXV, MINV, MINV, MAXV, MINV});
        dir_typed.push_back(t); dir_has.push_back(0);
        dir_tab.push_back('{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1,
                            -16'sd1, -16'sd1, -16'sd1});
        dir_typed.push_back(t); dir_has.push_back(0);

        for (i = 0; i < dir_tab.size(); i++) begin
            send_matrix(dir_tab[i], dir_has[i], dir_typed[i]);
            idle_gap();
        end

        for (i = 0; i < N_RANDOM; i++) begin
            mode = $urandom_range(0, 9);
            mode = (mode < 4) ? 0 : (mode < 9) ? 1 : 2;
            for (k = 0; k < 9; k++) begin
                m[k] = rand_elem(mode);
                if (mode == 2 && $urandom_range(0, 1)) m[k] = W'($urandom);
            end
            send_matrix(m, 0, t);
            if (i == N_RANDOM / 2) begin
                // hold off until the pipeline has drained
                start <= 1'b0;
                wait_cnt = 0;
                while (quat_expected.size() != 0 && wait_cnt < 10000) begin
                    @(posedge i_clk);
                    wait_cnt++;
                end
            end else if (i % 300 > 40) begin
                idle_gap();
            end
        end
        start <= 1'b0;

        wait_cnt = 0;
        while (quat_expected.size() != 0 && wait_cnt < 10000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d matrices, %0d results checked", n_sent, n_checked);
        $display("largest component w/x/y/z: %0d/%0d/%0d/%0d",
                 idx_seen[0], idx_seen[1], idx_seen[2], idx_seen[3]);
        if (n_errors == 0 && quat_expected.size() == 0) begin
            $display("rotation_matrix_to_quaternion regression: pass");
        end else begin
            $display("rotation_matrix_to_quaternion regression: fail");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/rmq_pkg.sv
rtl/rmq_front.sv
rtl/rmq_back.sv
rtl/rotation_matrix_to_quaternion.sv
tb/sv/testbench.sv
